// ----- rtl/core/wavetable_interpolating_lookup_unit_defines.svh -----
// Assertion macros shared by the wavetable lookup RTL.
`ifndef WAVETABLE_INTERPOLATING_LOOKUP_UNIT_DEFINES_SVH
`define WAVETABLE_INTERPOLATING_LOOKUP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WIL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WIL_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);
`else
`define WIL_ASSERT(label, clk, rst_n, prop, msg)
`define WIL_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg)
`endif
`endif

// ----- rtl/core/wil_pkg.sv -----
// Shared types and constants for the wavetable lookup unit.
`default_nettype none
package wil_pkg;

    // Default sizes of the design.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Reset values of the configuration registers.
    localparam int   TABLE_SIZE_RESET  = 1024;
    localparam logic INTERPOLATE_RESET = 1'b1;

    // Configuration register indexes.
    localparam int              CFG_INDEX_BITS  = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_SIZE  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERPOLATE = 1'b1;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_write;
    } item_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/wil_addr.sv -----
// Address stages: input capture, phase scaling and index/fraction split.
`default_nettype none
`include "wavetable_interpolating_lookup_unit_defines.svh"
module wil_addr #(
    parameter int TABLE_DEPTH = wil_pkg::DEF_TABLE_DEPTH,
    parameter int PHASE_BITS  = wil_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = wil_pkg::DEF_SAMPLE_BITS,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          command,
    input  logic [AW-1:0]                 entry_index,
    input  logic signed [SAMPLE_BITS-1:0] entry_value,
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic [CW-1:0]                 n_used,
    output wil_pkg::item_ctrl_t           ctrl_out,
    output logic [AW-1:0]                 rd_idx,
    output logic [AW-1:0]                 rd_nxt,
    output logic [PHASE_BITS-1:0]         frac,
    output logic [AW-1:0]                 wr_addr,
    output logic signed [SAMPLE_BITS-1:0] wr_value
);
    import wil_pkg::*;

    localparam int PW = PHASE_BITS + CW;

    item_ctrl_t                    ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic [AW-1:0]                 addr1_reg, addr2_reg, addr3_reg;
    logic signed [SAMPLE_BITS-1:0] value1_reg, value2_reg, value3_reg;
    logic [PHASE_BITS-1:0]         phase1_reg, frac3_reg;
    logic [PW-1:0]                 pos2_reg, pos2_next;
    logic [CW-1:0]                 idx_full, idx_clamp, nxt_full, nxt_clamp;
    logic [AW-1:0]                 idx3_reg, nxt3_reg;

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else
        begin
            ctrl1_reg.valid    <= accept;
            ctrl1_reg.is_write <= (command == CMD_WRITE);
            ctrl2_reg          <= ctrl1_reg;
            ctrl3_reg          <= ctrl2_reg;
        end
    end

    // Scale the phase by the number of entries in use.
    assign pos2_next = PW'(phase1_reg) * PW'(n_used);

    // Split the position and find the neighbor, wrapping at the last used entry.
    always_comb
    begin
        idx_full  = pos2_reg[PW-1:PHASE_BITS];
        idx_clamp = (idx_full >= n_used) ? (n_used - CW'(1)) : idx_full;
        nxt_full  = idx_clamp + CW'(1);
        nxt_clamp = (nxt_full >= n_used) ? '0 : nxt_full;
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        addr1_reg  <= entry_index;
        value1_reg <= entry_value;
        phase1_reg <= phase;
        addr2_reg  <= addr1_reg;
        value2_reg <= value1_reg;
        pos2_reg   <= pos2_next;
        addr3_reg  <= addr2_reg;
        value3_reg <= value2_reg;
        idx3_reg   <= idx_clamp[AW-1:0];
        nxt3_reg   <= nxt_clamp[AW-1:0];
        frac3_reg  <= pos2_reg[PHASE_BITS-1:0];
    end

    assign ctrl_out = ctrl3_reg;
    assign rd_idx   = idx3_reg;
    assign rd_nxt   = nxt3_reg;
    assign frac     = frac3_reg;
    assign wr_addr  = addr3_reg;
    assign wr_value = value3_reg;

    // Both read addresses of a sample item stay inside the used part of the table.
    `WIL_ASSERT(a_idx_in_range, clk, rst_n, (ctrl3_reg.valid && !ctrl3_reg.is_write) |-> (CW'(idx3_reg) < n_used), "index beyond table size")
    `WIL_ASSERT(a_nxt_in_range, clk, rst_n, (ctrl3_reg.valid && !ctrl3_reg.is_write) |-> (CW'(nxt3_reg) < n_used), "neighbor beyond table size")

endmodule
`default_nettype wire

// ----- rtl/core/wil_table.sv -----
// Wave table memory: one write port and two registered read ports.
`default_nettype none
module wil_table #(
    parameter int TABLE_DEPTH = wil_pkg::DEF_TABLE_DEPTH,
    parameter int PHASE_BITS  = wil_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = wil_pkg::DEF_SAMPLE_BITS,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wil_pkg::item_ctrl_t           ctrl_in,
    input  logic [AW-1:0]                 rd_idx,
    input  logic [AW-1:0]                 rd_nxt,
    input  logic [PHASE_BITS-1:0]         frac_in,
    input  logic [AW-1:0]                 wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_value,
    output wil_pkg::item_ctrl_t           ctrl_out,
    output logic signed [SAMPLE_BITS-1:0] p1,
    output logic signed [SAMPLE_BITS-1:0] p2,
    output logic [PHASE_BITS-1:0]         frac_out
);
    import wil_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] p1_reg, p2_reg;
    logic [PHASE_BITS-1:0]  frac_reg;
    item_ctrl_t             ctrl_reg;
    logic                   wr_en;

    // Writes outside the physical table are dropped.
    assign wr_en = ctrl_in.valid && ctrl_in.is_write && (CW'(wr_addr) < CW'(TABLE_DEPTH));

    // Memory: reads see the contents before a write in the same cycle;
    // both belong to the same item, and the reads of a write item are not used.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_value;
        end
        p1_reg   <= mem[rd_idx];
        p2_reg   <= mem[rd_nxt];
        frac_reg <= frac_in;
    end

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign p1       = p1_reg;
    assign p2       = p2_reg;
    assign frac_out = frac_reg;

endmodule
`default_nettype wire

// ----- rtl/core/wil_interp.sv -----
// Interpolation stages: difference, scale by fraction, add and output.
`default_nettype none
`include "wavetable_interpolating_lookup_unit_defines.svh"
module wil_interp #(
    parameter int PHASE_BITS  = wil_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = wil_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wil_pkg::item_ctrl_t           ctrl_in,
    input  logic signed [SAMPLE_BITS-1:0] p1,
    input  logic signed [SAMPLE_BITS-1:0] p2,
    input  logic [PHASE_BITS-1:0]         frac,
    input  logic                          interpolate,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] sample
);
    import wil_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PB = PHASE_BITS;

    item_ctrl_t              ctrl5_reg, ctrl6_reg;
    logic signed [SB:0]      diff5_reg, diff5_next;
    logic signed [SB-1:0]    p1_5_reg, p1_6_reg;
    logic [PB-1:0]           frac5_reg;
    logic signed [PB:0]      frac_s;
    logic signed [SB+PB+1:0] prod6_reg, prod6_next;
    logic [SB:0]             delta, sum;
    logic                    done_reg, done_next;
    logic signed [SB-1:0]    sample_reg, sample_next;
    logic                    in_sample, in_write;

    // Signed difference of the two neighbors.
    assign diff5_next = {p2[SB-1], p2} - {p1[SB-1], p1};

    // Scale the difference by the fraction.
    assign frac_s     = {1'b0, frac5_reg};
    assign prod6_next = diff5_reg * frac_s;

    // Dropping the low fraction bits of a signed product rounds toward minus infinity.
    always_comb
    begin
        delta       = prod6_reg[SB+PB:PB];
        sum         = {p1_6_reg[SB-1], p1_6_reg} + delta;
        sample_next = interpolate ? sum[SB-1:0] : p1_6_reg;
        done_next   = ctrl6_reg.valid && !ctrl6_reg.is_write;
    end

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl5_reg <= '0;
            ctrl6_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl5_reg <= ctrl_in;
            ctrl6_reg <= ctrl5_reg;
            done_reg  <= done_next;
        end
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        diff5_reg  <= diff5_next;
        p1_5_reg   <= p1;
        frac5_reg  <= frac;
        prod6_reg  <= prod6_next;
        p1_6_reg   <= p1_5_reg;
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

    // Kind of the item entering these stages.
    assign in_sample = ctrl_in.valid && !ctrl_in.is_write;
    assign in_write  = ctrl_in.valid && ctrl_in.is_write;

    // A sample item gives a result after the difference, product and output registers, and a write item gives none.
    `WIL_ASSERT_DELAY(a_sample_gives_result, clk, rst_n, in_sample, 3, done, "missing result")
    `WIL_ASSERT_DELAY(a_write_is_silent, clk, rst_n, in_write, 3, !done, "result for a write")

endmodule
`default_nettype wire

// ----- rtl/core/wavetable_interpolating_lookup_unit.sv -----
// Top level of the wavetable lookup unit with linear interpolation.
`default_nettype none
`include "wavetable_interpolating_lookup_unit_defines.svh"
// The unit takes one item in every clock cycle and busy is always low. A
// sample item gives its result on sample with done high for one cycle at the
// end of the pipeline; the pipeline has seven register stages (input
// capture, phase multiply, index split, table read, difference, fraction
// multiply, output add) and the receiver cannot hold results off, so results
// must be taken when done is high. A write item gives no result; it reaches
// the table at the read stage, so every item sees exactly the writes that
// were accepted before it. Entries must be written before they are read. The
// user must write configuration while no item is in flight; it is not enforced.
module wavetable_interpolating_lookup_unit #(
    parameter int TABLE_DEPTH = wil_pkg::DEF_TABLE_DEPTH,
    parameter int PHASE_BITS  = wil_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = wil_pkg::DEF_SAMPLE_BITS,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic [AW-1:0]                       entry_index,
    input  logic signed [SAMPLE_BITS-1:0]       entry_value,
    input  logic [PHASE_BITS-1:0]               phase,
    output logic                                done,
    output logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                cfg_write,
    input  logic [wil_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CW-1:0]                       cfg_data
);
    import wil_pkg::*;

    localparam int SIZE_RESET = (TABLE_SIZE_RESET < TABLE_DEPTH) ? TABLE_SIZE_RESET
                                                                 : TABLE_DEPTH;

    logic                          accept;
    logic [CW-1:0]                 n_used_reg, n_used_next;
    logic                          interp_reg;
    item_ctrl_t                    ctrl_a, ctrl_t;
    logic [AW-1:0]                 rd_idx, rd_nxt, wr_addr;
    logic [PHASE_BITS-1:0]         frac_a, frac_t;
    logic signed [SAMPLE_BITS-1:0] wr_value, p1, p2;
    logic                          accept_sample, accept_write, size_ok;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Table size is held already clamped to the range one to the table depth.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            n_used_next = CW'(1);
        end
        else if (cfg_data > CW'(TABLE_DEPTH))
        begin
            n_used_next = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_used_next = cfg_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_used_reg <= CW'(SIZE_RESET);
            interp_reg <= INTERPOLATE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TABLE_SIZE:  n_used_reg <= n_used_next;
                REG_INTERPOLATE: interp_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Address stages.
    wil_addr #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .phase       (phase),
        .n_used      (n_used_reg),
        .ctrl_out    (ctrl_a),
        .rd_idx      (rd_idx),
        .rd_nxt      (rd_nxt),
        .frac        (frac_a),
        .wr_addr     (wr_addr),
        .wr_value    (wr_value)
    );

    // Table read and write stage.
    wil_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_a),
        .rd_idx   (rd_idx),
        .rd_nxt   (rd_nxt),
        .frac_in  (frac_a),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .ctrl_out (ctrl_t),
        .p1       (p1),
        .p2       (p2),
        .frac_out (frac_t)
    );

    // Interpolation stages.
    wil_interp #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_in     (ctrl_t),
        .p1          (p1),
        .p2          (p2),
        .frac        (frac_t),
        .interpolate (interp_reg),
        .done        (done),
        .sample      (sample)
    );

    // Conditions watched by the checks below.
    assign accept_sample = accept && (command == CMD_SAMPLE);
    assign accept_write  = accept && (command == CMD_WRITE);
    assign size_ok       = (n_used_reg != '0) && (n_used_reg <= CW'(TABLE_DEPTH));

    // End-to-end latency of sample and write items.
    `WIL_ASSERT_DELAY(a_latency_sample, clk, rst_n, accept_sample, 7, done, "sample result late")
    `WIL_ASSERT_DELAY(a_latency_write, clk, rst_n, accept_write, 7, !done, "result for a write")
    `WIL_ASSERT(a_size_in_range, clk, rst_n, size_ok, "table size out of range")

endmodule
`default_nettype wire
